// File: hdl/midpoint_ellipse_rasterizer_macros.svh
// assertion macros shared by the ellipse rasterizer modules
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MER_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define MER_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/mer_pkg.sv
// types, constants and microprogram of the midpoint ellipse rasterizer
package mer_pkg;

    localparam int COORD_BITS  = 10;
    localparam int RADIUS_BITS = 9;
    localparam int OUT_BITS    = 12;
    localparam int SQ_W        = 2 * RADIUS_BITS;
    localparam int SLOPE_W     = 32;
    localparam int DEC_W       = 64;
    localparam int MUL_W       = 32;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int PC_W        = 6;
    localparam int PROG_LEN    = 55;
    localparam int ADDR_W      = 4;
    localparam int APB_DW      = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 2 * OUT_BITS;
    localparam int OUT_TUSER_W = 2;
    localparam int SUM_A       = (COORD_BITS > RADIUS_BITS) ? COORD_BITS + 1 : RADIUS_BITS + 1;
    localparam int SUM_W       = (SUM_A > OUT_BITS) ? SUM_A : OUT_BITS;

    localparam logic [COORD_BITS-1:0]  CX_RST = COORD_BITS'(200);
    localparam logic [COORD_BITS-1:0]  CY_RST = COORD_BITS'(250);
    localparam logic [RADIUS_BITS-1:0] RX_RST = RADIUS_BITS'(150);
    localparam logic [RADIUS_BITS-1:0] RY_RST = RADIUS_BITS'(50);

    typedef enum logic [1:0] {
        REG_CX = 2'd0,
        REG_CY = 2'd1,
        REG_RX = 2'd2,
        REG_RY = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        PH_R1   = 3'b001,
        PH_R2   = 3'b010,
        PH_DONE = 3'b100
    } t_phase;

    typedef enum logic [5:0] {
        OP_NOP, OP_IDLE,
        OP_M_RXRX, OP_M_RYRY, OP_M_SX, OP_M_SY, OP_M_RX2_RY,
        OP_M_RY2_TX, OP_M_P_TX, OP_M_RX2_TY, OP_M_P_TY, OP_M_RX2_RY2,
        OP_LD_RX2, OP_LD_RY2, OP_LD_SX, OP_LD_SY,
        OP_T_INIT, OP_T_P, OP_T_ADD4P, OP_T_SUB4P,
        OP_DEC_T, OP_DEC_T_R2, OP_DEC_D1, OP_DEC_R1N, OP_DEC_D2, OP_DEC_R2P,
        OP_RST_POS, OP_INC_X, OP_DEC_Y, OP_SET_DONE,
        OP_EMIT0, OP_EMIT1, OP_EMIT2, OP_EMIT3, OP_EMIT_DONE
    } t_op;

    typedef enum logic [3:0] {
        C_NEXT, C_JMP, C_WAIT_IN, C_DISPATCH, C_NEG, C_R2P, C_YZ, C_NOSW,
        C_WOUT, C_WOUT_J
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_ctrl;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic   in_valid;
        logic   restart;
        logic   dec_neg;
        logic   dec_zero;
        logic   y_zero;
        logic   slope_ge;
        logic   out_free;
        t_phase phase;
    } t_stat;

    // command from the sequencer to the datapath
    typedef struct packed {
        t_op  op;
        logic fire;
        logic in_ready;
    } t_cmd;

    localparam logic [PC_W-1:0] L_IDLE = PC_W'(0);
    localparam logic [PC_W-1:0] L_RST  = PC_W'(5);
    localparam logic [PC_W-1:0] L_R1   = PC_W'(14);
    localparam logic [PC_W-1:0] L_R1N  = PC_W'(21);
    localparam logic [PC_W-1:0] L_R2   = PC_W'(26);
    localparam logic [PC_W-1:0] L_R2P  = PC_W'(33);
    localparam logic [PC_W-1:0] L_SET  = PC_W'(38);
    localparam logic [PC_W-1:0] L_FIN  = PC_W'(49);
    localparam logic [PC_W-1:0] L_EMIT = PC_W'(50);
    localparam logic [PC_W-1:0] L_DONE = PC_W'(54);

    function automatic t_ctrl f_cw(input t_op op, input t_cond cond,
                                   input logic [PC_W-1:0] tgt);
        t_ctrl cw;
        cw.op     = op;
        cw.cond   = cond;
        cw.target = tgt;
        return cw;
    endfunction

    function automatic t_ctrl f_prog(input logic [PC_W-1:0] pc);
        t_ctrl cw;
        case (pc)
            // fetch item, square the radii, branch on kind
            PC_W'(0):  cw = f_cw(OP_IDLE,      C_WAIT_IN,  L_IDLE);
            PC_W'(1):  cw = f_cw(OP_M_RXRX,    C_NEXT,     L_IDLE);
            PC_W'(2):  cw = f_cw(OP_LD_RX2,    C_NEXT,     L_IDLE);
            PC_W'(3):  cw = f_cw(OP_M_RYRY,    C_NEXT,     L_IDLE);
            PC_W'(4):  cw = f_cw(OP_LD_RY2,    C_DISPATCH, L_IDLE);
            // restart: d = 4ry2 - 4rx2*ry + rx2
            PC_W'(5):  cw = f_cw(OP_RST_POS,   C_NEXT,     L_IDLE);
            PC_W'(6):  cw = f_cw(OP_T_INIT,    C_NEXT,     L_IDLE);
            PC_W'(7):  cw = f_cw(OP_M_RX2_RY,  C_NEXT,     L_IDLE);
            PC_W'(8):  cw = f_cw(OP_T_SUB4P,   C_NEXT,     L_IDLE);
            PC_W'(9):  cw = f_cw(OP_DEC_T,     C_NEXT,     L_IDLE);
            PC_W'(10): cw = f_cw(OP_M_SX,      C_NEXT,     L_IDLE);
            PC_W'(11): cw = f_cw(OP_LD_SX,     C_NEXT,     L_IDLE);
            PC_W'(12): cw = f_cw(OP_M_SY,      C_NEXT,     L_IDLE);
            PC_W'(13): cw = f_cw(OP_LD_SY,     C_JMP,      L_SET);
            // region one, diagonal move
            PC_W'(14): cw = f_cw(OP_INC_X,     C_NEG,      L_R1N);
            PC_W'(15): cw = f_cw(OP_DEC_Y,     C_NEXT,     L_IDLE);
            PC_W'(16): cw = f_cw(OP_M_SX,      C_NEXT,     L_IDLE);
            PC_W'(17): cw = f_cw(OP_LD_SX,     C_NEXT,     L_IDLE);
            PC_W'(18): cw = f_cw(OP_M_SY,      C_NEXT,     L_IDLE);
            PC_W'(19): cw = f_cw(OP_LD_SY,     C_NEXT,     L_IDLE);
            PC_W'(20): cw = f_cw(OP_DEC_D1,    C_JMP,      L_SET);
            // region one, x move only
            PC_W'(21): cw = f_cw(OP_M_SX,      C_NEXT,     L_IDLE);
            PC_W'(22): cw = f_cw(OP_LD_SX,     C_NEXT,     L_IDLE);
            PC_W'(23): cw = f_cw(OP_M_SY,      C_NEXT,     L_IDLE);
            PC_W'(24): cw = f_cw(OP_LD_SY,     C_NEXT,     L_IDLE);
            PC_W'(25): cw = f_cw(OP_DEC_R1N,   C_JMP,      L_SET);
            // region two, diagonal move
            PC_W'(26): cw = f_cw(OP_DEC_Y,     C_R2P,      L_R2P);
            PC_W'(27): cw = f_cw(OP_INC_X,     C_NEXT,     L_IDLE);
            PC_W'(28): cw = f_cw(OP_M_SX,      C_NEXT,     L_IDLE);
            PC_W'(29): cw = f_cw(OP_LD_SX,     C_NEXT,     L_IDLE);
            PC_W'(30): cw = f_cw(OP_M_SY,      C_NEXT,     L_IDLE);
            PC_W'(31): cw = f_cw(OP_LD_SY,     C_NEXT,     L_IDLE);
            PC_W'(32): cw = f_cw(OP_DEC_D2,    C_JMP,      L_SET);
            // region two, y move only
            PC_W'(33): cw = f_cw(OP_M_SX,      C_NEXT,     L_IDLE);
            PC_W'(34): cw = f_cw(OP_LD_SX,     C_NEXT,     L_IDLE);
            PC_W'(35): cw = f_cw(OP_M_SY,      C_NEXT,     L_IDLE);
            PC_W'(36): cw = f_cw(OP_LD_SY,     C_NEXT,     L_IDLE);
            PC_W'(37): cw = f_cw(OP_DEC_R2P,   C_JMP,      L_SET);
            // settle: finish on y zero, else maybe switch to region two
            PC_W'(38): cw = f_cw(OP_NOP,       C_YZ,       L_FIN);
            PC_W'(39): cw = f_cw(OP_NOP,       C_NOSW,     L_EMIT);
            PC_W'(40): cw = f_cw(OP_M_RY2_TX,  C_NEXT,     L_IDLE);
            PC_W'(41): cw = f_cw(OP_M_P_TX,    C_NEXT,     L_IDLE);
            PC_W'(42): cw = f_cw(OP_T_P,       C_NEXT,     L_IDLE);
            PC_W'(43): cw = f_cw(OP_M_RX2_TY,  C_NEXT,     L_IDLE);
            PC_W'(44): cw = f_cw(OP_M_P_TY,    C_NEXT,     L_IDLE);
            PC_W'(45): cw = f_cw(OP_T_ADD4P,   C_NEXT,     L_IDLE);
            PC_W'(46): cw = f_cw(OP_M_RX2_RY2, C_NEXT,     L_IDLE);
            PC_W'(47): cw = f_cw(OP_T_SUB4P,   C_NEXT,     L_IDLE);
            PC_W'(48): cw = f_cw(OP_DEC_T_R2,  C_JMP,      L_EMIT);
            PC_W'(49): cw = f_cw(OP_SET_DONE,  C_NEXT,     L_IDLE);
            // four symmetric points, or the done result
            PC_W'(50): cw = f_cw(OP_EMIT0,     C_WOUT,     L_IDLE);
            PC_W'(51): cw = f_cw(OP_EMIT1,     C_WOUT,     L_IDLE);
            PC_W'(52): cw = f_cw(OP_EMIT2,     C_WOUT,     L_IDLE);
            PC_W'(53): cw = f_cw(OP_EMIT3,     C_WOUT_J,   L_IDLE);
            PC_W'(54): cw = f_cw(OP_EMIT_DONE, C_WOUT_J,   L_IDLE);
            default:   cw = f_cw(OP_NOP,       C_JMP,      L_IDLE);
        endcase
        return cw;
    endfunction

endpackage

// File: hdl/mer_seq.sv
// microprogram sequencer: step counter, control rom and conditional jumps
`include "midpoint_ellipse_rasterizer_macros.svh"

module mer_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mer_pkg::t_stat i_stat,
    output mer_pkg::t_cmd  o_cmd
);
    import mer_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           w_cw;
    logic            w_fire;

    assign w_cw = f_prog(r_pc);

    always_comb begin
        n_pc   = r_pc + PC_W'(1);
        w_fire = 1'b1;
        case (w_cw.cond)
            C_NEXT: begin
            end
            C_JMP: begin
                n_pc = w_cw.target;
            end
            C_WAIT_IN: begin
                if (!i_stat.in_valid) begin
                    n_pc   = r_pc;
                    w_fire = 1'b0;
                end
            end
            C_DISPATCH: begin
                if (i_stat.restart) begin
                    n_pc = L_RST;
                end else begin
                    case (i_stat.phase)
                        PH_R1:   n_pc = L_R1;
                        PH_R2:   n_pc = L_R2;
                        default: n_pc = L_DONE;
                    endcase
                end
            end
            C_NEG: begin
                if (i_stat.dec_neg) begin
                    n_pc = w_cw.target;
                end
            end
            C_R2P: begin
                // y-only move while the decision is strictly positive
                if (!i_stat.dec_neg && !i_stat.dec_zero) begin
                    n_pc = w_cw.target;
                end
            end
            C_YZ: begin
                if (i_stat.y_zero) begin
                    n_pc = w_cw.target;
                end
            end
            C_NOSW: begin
                if (!(i_stat.phase == PH_R1 && i_stat.slope_ge)) begin
                    n_pc = w_cw.target;
                end
            end
            C_WOUT: begin
                if (!i_stat.out_free) begin
                    n_pc   = r_pc;
                    w_fire = 1'b0;
                end
            end
            C_WOUT_J: begin
                if (!i_stat.out_free) begin
                    n_pc   = r_pc;
                    w_fire = 1'b0;
                end else begin
                    n_pc = w_cw.target;
                end
            end
            default: begin
                n_pc = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= L_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_cmd.op       = w_cw.op;
    assign o_cmd.fire     = w_fire;
    assign o_cmd.in_ready = (w_cw.cond == C_WAIT_IN);

    `MER_ASSERT_IMP(a_pc_range, 1'b1, r_pc < PC_W'(PROG_LEN))
    `MER_ASSERT_NXT(a_hold_pc, !w_fire, r_pc == $past(r_pc))
    `MER_ASSERT_IMP(a_ready_idle, o_cmd.in_ready, r_pc == L_IDLE)

endmodule

// File: hdl/midpoint_ellipse_rasterizer.sv
// top level: config registers, shared multiplier datapath and output register
// Axis-aligned midpoint ellipse rasterizer. Centre and radii are set over the APB
// port (center_x, center_y, radius_x, radius_y at 0x0, 0x4, 0x8, 0xC). An input
// with restart set begins a new outline at (0, radius_y); each input without it
// advances one step in x, in y or in both. Every plotting input returns four
// points, last one flagged by tlast; once the outline is complete a step returns
// a single invalid result with the done flag set. Inputs are processed one at a
// time by a microprogrammed datapath built around one shared 32x32 multiplier.
`include "midpoint_ellipse_rasterizer_macros.svh"

module midpoint_ellipse_rasterizer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // stream in
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [mer_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,   // [0] restart
    // stream out
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [mer_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,   // point_x, point_y
    output logic [mer_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser,   // point_valid, done_res
    output logic                              o_m_axis_tlast,   // last_of_step
    // config
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mer_pkg::ADDR_W-1:0]        paddr,
    input  logic [mer_pkg::APB_DW-1:0]        pwdata,
    output logic [mer_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);
    import mer_pkg::*;

    logic [COORD_BITS-1:0]  r_cx, r_cy;
    logic [RADIUS_BITS-1:0] r_rx, r_ry;
    logic [RADIUS_BITS-1:0] r_x, r_y;
    logic [DEC_W-1:0]       r_dec, r_t;
    logic [SLOPE_W-1:0]     r_sx, r_sy;
    logic [SQ_W-1:0]        r_rx2, r_ry2;
    logic [PROD_W-1:0]      r_p;
    t_phase                 r_phase;
    logic                   r_rs;
    logic                   r_ovalid;
    logic                   n_ovalid;
    logic [OUT_BITS-1:0]    r_ox, r_oy;
    logic                   r_opv, r_olast, r_odone;

    t_stat                  w_stat;
    t_cmd                   w_cmd;
    t_reg                   w_reg;
    logic                   w_cfg_wr;
    logic                   w_out_free;
    logic                   w_load;
    logic                   w_mul;
    logic [MUL_W-1:0]       w_ma, w_mb;
    logic [RADIUS_BITS:0]   w_x2, w_y2, w_tx;
    logic [RADIUS_BITS-1:0] w_ty;
    logic [DEC_W-1:0]       w_sx64, w_sy64, w_rx2_64, w_ry2_64, w_p4;
    logic [SUM_W-1:0]       w_xp, w_xm, w_yp, w_ym;

    // config port
    assign pready   = 1'b1;
    assign w_reg    = t_reg'(paddr[ADDR_W-1:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= CX_RST;
            r_cy <= CY_RST;
            r_rx <= RX_RST;
            r_ry <= RY_RST;
        end else if (w_cfg_wr) begin
            case (w_reg)
                REG_CX:  r_cx <= pwdata[COORD_BITS-1:0];
                REG_CY:  r_cy <= pwdata[COORD_BITS-1:0];
                REG_RX:  r_rx <= pwdata[RADIUS_BITS-1:0];
                REG_RY:  r_ry <= pwdata[RADIUS_BITS-1:0];
                default: r_cx <= r_cx;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_CX:  prdata = APB_DW'(r_cx);
            REG_CY:  prdata = APB_DW'(r_cy);
            REG_RX:  prdata = APB_DW'(r_rx);
            REG_RY:  prdata = APB_DW'(r_ry);
            default: prdata = '0;
        endcase
    end

    // sequencer
    assign w_out_free      = !r_ovalid || i_m_axis_tready;
    assign w_stat.in_valid = i_s_axis_tvalid;
    assign w_stat.restart  = r_rs;
    assign w_stat.dec_neg  = r_dec[DEC_W-1];
    assign w_stat.dec_zero = (r_dec == '0);
    assign w_stat.y_zero   = (r_y == '0);
    assign w_stat.slope_ge = (r_sx >= r_sy);
    assign w_stat.out_free = w_out_free;
    assign w_stat.phase    = r_phase;

    mer_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    assign o_s_axis_tready = w_cmd.in_ready;

    // operand forms
    assign w_x2 = {r_x, 1'b0};
    assign w_y2 = {r_y, 1'b0};
    assign w_tx = {r_x, 1'b1};
    assign w_ty = r_y - RADIUS_BITS'(1);

    always_comb begin
        w_mul = 1'b1;
        w_ma  = '0;
        w_mb  = '0;
        case (w_cmd.op)
            OP_M_RXRX: begin
                w_ma = MUL_W'(r_rx);
                w_mb = MUL_W'(r_rx);
            end
            OP_M_RYRY: begin
                w_ma = MUL_W'(r_ry);
                w_mb = MUL_W'(r_ry);
            end
            OP_M_SX: begin
                w_ma = MUL_W'(r_ry2);
                w_mb = MUL_W'(w_x2);
            end
            OP_M_SY: begin
                w_ma = MUL_W'(r_rx2);
                w_mb = MUL_W'(w_y2);
            end
            OP_M_RX2_RY: begin
                w_ma = MUL_W'(r_rx2);
                w_mb = MUL_W'(r_ry);
            end
            OP_M_RY2_TX: begin
                w_ma = MUL_W'(r_ry2);
                w_mb = MUL_W'(w_tx);
            end
            OP_M_P_TX: begin
                w_ma = r_p[MUL_W-1:0];
                w_mb = MUL_W'(w_tx);
            end
            OP_M_RX2_TY: begin
                w_ma = MUL_W'(r_rx2);
                w_mb = MUL_W'(w_ty);
            end
            OP_M_P_TY: begin
                w_ma = r_p[MUL_W-1:0];
                w_mb = MUL_W'(w_ty);
            end
            OP_M_RX2_RY2: begin
                w_ma = MUL_W'(r_rx2);
                w_mb = MUL_W'(r_ry2);
            end
            default: begin
                w_mul = 1'b0;
            end
        endcase
    end

    // decision terms, all wrap modulo 2^64
    assign w_sx64   = DEC_W'(r_sx);
    assign w_sy64   = DEC_W'(r_sy);
    assign w_rx2_64 = DEC_W'(r_rx2);
    assign w_ry2_64 = DEC_W'(r_ry2);
    assign w_p4     = DEC_W'(r_p) << 2;

    // symmetric coordinates
    assign w_xp = SUM_W'(r_cx) + SUM_W'(r_x);
    assign w_xm = SUM_W'(r_cx) - SUM_W'(r_x);
    assign w_yp = SUM_W'(r_cy) + SUM_W'(r_y);
    assign w_ym = SUM_W'(r_cy) - SUM_W'(r_y);

    assign w_load = w_cmd.fire && (w_cmd.op == OP_EMIT0 || w_cmd.op == OP_EMIT1 ||
                                   w_cmd.op == OP_EMIT2 || w_cmd.op == OP_EMIT3 ||
                                   w_cmd.op == OP_EMIT_DONE);
    assign n_ovalid = w_load || (r_ovalid && !i_m_axis_tready);

    // position, decision and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_dec    <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_phase  <= PH_DONE;
            r_rs     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            if (w_cmd.fire) begin
                case (w_cmd.op)
                    OP_IDLE:     r_rs <= i_s_axis_tdata[0];
                    OP_LD_SX:    r_sx <= r_p[SLOPE_W-1:0];
                    OP_LD_SY:    r_sy <= r_p[SLOPE_W-1:0];
                    OP_DEC_T:    r_dec <= r_t;
                    OP_DEC_T_R2: begin
                        r_dec   <= r_t;
                        r_phase <= PH_R2;
                    end
                    OP_DEC_D1:   r_dec <= r_dec + ((w_sx64 - w_sy64 + w_ry2_64) << 2);
                    OP_DEC_R1N:  r_dec <= r_dec + ((w_sx64 + w_ry2_64) << 2);
                    OP_DEC_D2:   r_dec <= r_dec + ((w_sx64 - w_sy64 + w_rx2_64) << 2);
                    OP_DEC_R2P:  r_dec <= r_dec + ((w_rx2_64 - w_sy64) << 2);
                    OP_RST_POS: begin
                        r_x     <= '0;
                        r_y     <= r_ry;
                        r_phase <= PH_R1;
                    end
                    OP_INC_X:    r_x <= r_x + RADIUS_BITS'(1);
                    OP_DEC_Y:    r_y <= r_y - RADIUS_BITS'(1);
                    OP_SET_DONE: r_phase <= PH_DONE;
                    default:     r_rs <= r_rs;
                endcase
            end
        end
    end

    // product, scratch, squares and output payload
    always_ff @(posedge i_clk) begin
        if (w_mul) begin
            r_p <= w_ma * w_mb;
        end
        if (w_cmd.fire) begin
            case (w_cmd.op)
                OP_LD_RX2:  r_rx2 <= r_p[SQ_W-1:0];
                OP_LD_RY2:  r_ry2 <= r_p[SQ_W-1:0];
                OP_T_INIT:  r_t <= w_rx2_64 + (w_ry2_64 << 2);
                OP_T_P:     r_t <= DEC_W'(r_p);
                OP_T_ADD4P: r_t <= r_t + w_p4;
                OP_T_SUB4P: r_t <= r_t - w_p4;
                OP_EMIT0: begin
                    r_ox    <= w_xp[OUT_BITS-1:0];
                    r_oy    <= w_yp[OUT_BITS-1:0];
                    r_opv   <= 1'b1;
                    r_olast <= 1'b0;
                    r_odone <= 1'b0;
                end
                OP_EMIT1: begin
                    r_ox    <= w_xm[OUT_BITS-1:0];
                    r_oy    <= w_yp[OUT_BITS-1:0];
                    r_opv   <= 1'b1;
                    r_olast <= 1'b0;
                    r_odone <= 1'b0;
                end
                OP_EMIT2: begin
                    r_ox    <= w_xp[OUT_BITS-1:0];
                    r_oy    <= w_ym[OUT_BITS-1:0];
                    r_opv   <= 1'b1;
                    r_olast <= 1'b0;
                    r_odone <= 1'b0;
                end
                OP_EMIT3: begin
                    r_ox    <= w_xm[OUT_BITS-1:0];
                    r_oy    <= w_ym[OUT_BITS-1:0];
                    r_opv   <= 1'b1;
                    r_olast <= 1'b1;
                    r_odone <= 1'b0;
                end
                OP_EMIT_DONE: begin
                    r_ox    <= '0;
                    r_oy    <= '0;
                    r_opv   <= 1'b0;
                    r_olast <= 1'b1;
                    r_odone <= 1'b1;
                end
                default: r_t <= r_t;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_oy, r_ox};
    assign o_m_axis_tuser  = {r_odone, r_opv};
    assign o_m_axis_tlast  = r_olast;

    `MER_ASSERT_IMP(a_no_load_idle, o_s_axis_tready, !w_load)
    `MER_ASSERT_NXT(a_load_shows, w_load, r_ovalid)
    `MER_ASSERT_IMP(a_done_res_form, r_ovalid && r_odone, !r_opv && r_olast)
    `MER_ASSERT_IMP(a_y_zero_done, o_s_axis_tready && r_y == '0, r_phase == PH_DONE)

endmodule
